// ===== rtl/kmps_pkg.sv =====
package kmps_pkg;

    localparam int MAX_PATTERN = 1024;
    localparam int MAX_TEXT    = 65536;
    localparam int PAT_AW      = $clog2(MAX_PATTERN);
    localparam int LEN_W       = PAT_AW + 1;
    localparam int TPOS_SAT    = MAX_TEXT + MAX_PATTERN;
    localparam int TPOS_W      = $clog2(TPOS_SAT + 1);
    localparam int SYM_W       = 8;
    localparam int POS_W       = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = Q_AW + 1;

    typedef struct packed {
        logic             operation;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_beat;

    typedef enum logic [1:0] {
        KIND_PAT,
        KIND_PAT_LAST,
        KIND_TXT,
        KIND_TXT_LAST
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [SYM_W-1:0] sym;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_CMP,
        ST_TEXT_GO,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_TEXT_END
    } t_back_state;

endpackage

// ===== rtl/kmps_front.sv =====
module kmps_front
    import kmps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_beat i_in_data,
    output logic     o_in_stall,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_accept;

    assign o_in_stall = r_valid && i_q_full;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_cmd    = r_cmd;
    assign w_accept   = i_in_valid && !o_in_stall;

    // classify the beat
    always_comb begin
        n_cmd     = r_cmd;
        n_cmd.sym = i_in_data.symbol;
        case ({i_in_data.operation, i_in_data.last})
            2'b00:   n_cmd.kind = KIND_PAT;
            2'b01:   n_cmd.kind = KIND_PAT_LAST;
            2'b10:   n_cmd.kind = KIND_TXT;
            default: n_cmd.kind = KIND_TXT_LAST;
        endcase
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/kmps_queue.sv =====
module kmps_queue
    import kmps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;
    logic            w_pop;

    assign o_full       = (r_count == Q_CW'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];
    assign w_pop        = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (w_pop && !i_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/kmps_back.sv =====
module kmps_back
    import kmps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    logic [SYM_W-1:0]  r_pat  [MAX_PATTERN];
    logic [PAT_AW-1:0] r_fail [MAX_PATTERN];

    t_back_state       r_state;
    t_back_state       n_state;
    logic [LEN_W-1:0]  r_plen;
    logic [LEN_W-1:0]  n_plen;
    logic              r_inv;
    logic              n_inv;
    logic              r_loading;
    logic              n_loading;
    logic [PAT_AW-1:0] r_mlen;
    logic [PAT_AW-1:0] n_mlen;
    logic [TPOS_W-1:0] r_tpos;
    logic [TPOS_W-1:0] n_tpos;
    logic              r_reported;
    logic              n_reported;
    logic              r_hit;
    logic              n_hit;
    logic [POS_W-1:0]  r_hit_pos;
    logic [POS_W-1:0]  n_hit_pos;
    logic              r_is_text;
    logic              n_is_text;
    logic [SYM_W-1:0]  r_sym;
    logic [SYM_W-1:0]  n_sym;
    logic              r_last;
    logic              n_last;
    logic [LEN_W-1:0]  r_bi;
    logic [LEN_W-1:0]  n_bi;
    logic [PAT_AW-1:0] r_bk;
    logic [PAT_AW-1:0] n_bk;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_beat         r_out;
    t_out_beat         n_out;

    logic [SYM_W-1:0]  r_pat_a;
    logic [SYM_W-1:0]  r_pat_b;
    logic [PAT_AW-1:0] r_fail_lo;
    logic [PAT_AW-1:0] r_fail_hi;

    logic [PAT_AW-1:0] w_pa;
    logic [PAT_AW-1:0] w_pb;
    logic [PAT_AW-1:0] w_flo;
    logic [PAT_AW-1:0] w_fhi;
    logic              w_pat_we;
    logic [PAT_AW-1:0] w_pat_wa;
    logic              w_fail_we;
    logic [PAT_AW-1:0] w_fail_wa;
    logic [PAT_AW-1:0] w_fail_wd;

    logic              v_start_build;
    logic [LEN_W-1:0]  v_m1;
    logic [TPOS_W:0]   v_start;
    logic              v_emit;
    logic              w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_pa  = (r_state == ST_BUILD_RD) ? r_bi[PAT_AW-1:0] : r_mlen;
    assign w_pb  = r_bk;
    assign w_flo = ((r_state == ST_BUILD_RD) ? r_bk : r_mlen) - PAT_AW'(1);
    assign w_fhi = r_mlen;

    always_comb begin
        n_state       = r_state;
        n_plen        = r_plen;
        n_inv         = r_inv;
        n_loading     = r_loading;
        n_mlen        = r_mlen;
        n_tpos        = r_tpos;
        n_reported    = r_reported;
        n_hit         = r_hit;
        n_hit_pos     = r_hit_pos;
        n_is_text     = r_is_text;
        n_sym         = r_sym;
        n_last        = r_last;
        n_bi          = r_bi;
        n_bk          = r_bk;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        o_pop         = 1'b0;
        w_pat_we      = 1'b0;
        w_pat_wa      = r_plen[PAT_AW-1:0];
        w_fail_we     = 1'b0;
        w_fail_wa     = r_bi[PAT_AW-1:0];
        w_fail_wd     = '0;
        v_start_build = 1'b0;
        v_m1          = '0;
        v_start       = '0;
        v_emit        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop     = 1'b1;
                    n_sym     = i_head.cmd.sym;
                    n_last    = (i_head.cmd.kind == KIND_PAT_LAST) ||
                                (i_head.cmd.kind == KIND_TXT_LAST);
                    n_is_text = (i_head.cmd.kind == KIND_TXT) ||
                                (i_head.cmd.kind == KIND_TXT_LAST);
                    if (!n_is_text) begin
                        if (!r_loading) begin
                            n_plen     = '0;
                            n_inv      = 1'b0;
                            n_mlen     = '0;
                            n_tpos     = '0;
                            n_reported = 1'b0;
                        end
                        if (n_plen < LEN_W'(MAX_PATTERN)) begin
                            w_pat_we = 1'b1;
                            w_pat_wa = n_plen[PAT_AW-1:0];
                            n_plen   = n_plen + LEN_W'(1);
                        end else begin
                            n_inv = 1'b1;
                        end
                        n_loading = !n_last;
                        if (n_last) begin
                            n_mlen        = '0;
                            n_tpos        = '0;
                            n_reported    = 1'b0;
                            v_start_build = !n_inv;
                        end
                    end else if (r_loading) begin
                        n_loading     = 1'b0;
                        n_mlen        = '0;
                        n_tpos        = '0;
                        n_reported    = 1'b0;
                        v_start_build = !r_inv && (r_plen != '0);
                        n_state       = ST_TEXT_GO;
                    end else begin
                        n_state = ST_TEXT_GO;
                    end
                    if (v_start_build) begin
                        // first entry of the failure table is always zero
                        w_fail_we = 1'b1;
                        w_fail_wa = '0;
                        w_fail_wd = '0;
                        n_bi      = LEN_W'(1);
                        n_bk      = '0;
                        if (n_plen > LEN_W'(1)) begin
                            n_state = ST_BUILD_RD;
                        end
                    end
                end
            end
            ST_BUILD_RD: begin
                n_state = ST_BUILD_CMP;
            end
            ST_BUILD_CMP: begin
                if (r_pat_a == r_pat_b) begin
                    w_fail_we = 1'b1;
                    w_fail_wd = r_bk + PAT_AW'(1);
                    n_bk      = r_bk + PAT_AW'(1);
                    n_bi      = r_bi + LEN_W'(1);
                end else if (r_bk != '0) begin
                    n_bk = r_fail_lo;
                end else begin
                    w_fail_we = 1'b1;
                    w_fail_wd = '0;
                    n_bi      = r_bi + LEN_W'(1);
                end
                if (n_bi >= r_plen) begin
                    n_state = r_is_text ? ST_TEXT_GO : ST_IDLE;
                end else begin
                    n_state = ST_BUILD_RD;
                end
            end
            ST_TEXT_GO: begin
                n_hit = 1'b0;
                if (!r_reported && !r_inv && (r_plen != '0)) begin
                    n_state = ST_SEARCH_RD;
                end else begin
                    n_state = ST_TEXT_END;
                end
            end
            ST_SEARCH_RD: begin
                n_state = ST_SEARCH_CMP;
            end
            ST_SEARCH_CMP: begin
                if ((r_mlen != '0) && (r_pat_a != r_sym)) begin
                    n_mlen  = r_fail_lo;
                    n_state = ST_SEARCH_RD;
                end else begin
                    v_m1 = {1'b0, r_mlen} + LEN_W'(r_pat_a == r_sym);
                    if (v_m1 == r_plen) begin
                        v_start = {1'b0, r_tpos} + (TPOS_W+1)'(1) - (TPOS_W+1)'(r_plen);
                        if (v_start < (TPOS_W+1)'(MAX_TEXT)) begin
                            n_hit      = 1'b1;
                            n_hit_pos  = v_start[POS_W-1:0];
                            n_reported = 1'b1;
                        end
                        n_mlen = r_fail_hi;
                    end else begin
                        n_mlen = v_m1[PAT_AW-1:0];
                    end
                    n_state = ST_TEXT_END;
                end
            end
            ST_TEXT_END: begin
                v_emit = r_hit || (r_last && !r_reported);
                if (!v_emit || w_out_free) begin
                    if (v_emit) begin
                        n_out_valid    = 1'b1;
                        n_out.found    = r_hit;
                        n_out.position = r_hit ? r_hit_pos : '0;
                    end
                    if (r_tpos < TPOS_W'(TPOS_SAT)) begin
                        n_tpos = r_tpos + TPOS_W'(1);
                    end
                    if (r_last) begin
                        n_mlen     = '0;
                        n_tpos     = '0;
                        n_reported = 1'b0;
                    end
                    n_hit   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_plen      <= '0;
            r_inv       <= 1'b0;
            r_loading   <= 1'b0;
            r_mlen      <= '0;
            r_tpos      <= '0;
            r_reported  <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_plen      <= n_plen;
            r_inv       <= n_inv;
            r_loading   <= n_loading;
            r_mlen      <= n_mlen;
            r_tpos      <= n_tpos;
            r_reported  <= n_reported;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_pos <= n_hit_pos;
        r_is_text <= n_is_text;
        r_sym     <= n_sym;
        r_last    <= n_last;
        r_bi      <= n_bi;
        r_bk      <= n_bk;
        r_out     <= n_out;
    end

    // pattern store and failure table, registered reads
    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            r_pat[w_pat_wa] <= n_sym;
        end
        r_pat_a <= r_pat[w_pa];
        r_pat_b <= r_pat[w_pb];
    end

    always_ff @(posedge i_clk) begin
        if (w_fail_we) begin
            r_fail[w_fail_wa] <= w_fail_wd;
        end
        r_fail_lo <= r_fail[w_flo];
        r_fail_hi <= r_fail[w_fhi];
    end

endmodule

// ===== rtl/kmp_substring_search_core.sv =====
// knuth-morris-pratt search core
// input channel (i_in_valid / o_in_stall / i_in_data): one beat per byte.
//   operation 0 loads a pattern byte, operation 1 streams a text byte; last
//   closes the pattern or the text. a text byte during a pattern load closes
//   the pattern first. patterns longer than 1024 bytes give not-found.
// output channel (o_out_valid / i_out_stall / o_out_data): at most one beat
//   per text, either the start of the first match or not-found with
//   position zero. nothing is produced for pattern bytes.
// a front register and a four-entry command queue take beats while the
//   sequencer is busy. the sequencer takes each pattern byte in ST_IDLE;
//   the last pattern byte starts the failure table build, which runs
//   ST_BUILD_RD then ST_BUILD_CMP for each comparison. a text byte passes
//   ST_TEXT_GO, then ST_SEARCH_RD and ST_SEARCH_CMP for each comparison while
//   searching, then ST_TEXT_END; over a text there are at most two comparisons
//   per byte. each comparison waits on the registered reads of both stores.
// a result is registered in the output register from ST_TEXT_END of its
//   text byte, after the byte passes the front register and the queue.
// synchronous reset clears all control state; store contents are not cleared
//   and need no sweep, so beats are taken as soon as reset is released.
// a stalled output holds its beat; the sequencer waits only when it has a
//   new result and the output register holds a beat that is stalled.
module kmp_substring_search_core
    import kmps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    logic    w_q_full;
    logic    w_q_push;
    t_cmd    w_q_cmd;
    logic    w_q_pop;
    t_q_head w_q_head;

    kmps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_cmd    (w_q_cmd)
    );

    kmps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head)
    );

    kmps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_q_head),
        .o_pop       (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("queue push while full");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_head.valid)
        else $error("queue pop while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_q_head.valid)
        else $error("output or queue not empty after reset");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.position == '0)
        else $error("not-found beat with nonzero position");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb
    import kmps_pkg::*;
;

    localparam bit OP_PATTERN      = 1'b0;
    localparam bit OP_TEXT         = 1'b1;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_AT         = 10;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_BEATS    = 340;
    localparam int DRAIN_CYCLES    = 50;
    localparam int MAX_SHOWN_FAILS = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_beat  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;
    logic      i_out_stall;

    kmp_substring_search_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // search state mirrored from the block
    logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
    int unsigned      lps_mem [MAX_PATTERN];
    int unsigned      pat_len     = 0;
    int unsigned      match_len   = 0;
    longint unsigned  txt_pos     = 0;
    bit               pat_bad     = 1'b0;
    bit               pat_loading = 1'b0;
    bit               hit_done    = 1'b0;
    t_out_beat        verdict_q [$];

    t_in_beat         beat_q [$];
    logic [SYM_W-1:0] seq_bytes [$];
    logic [SYM_W-1:0] pat_bytes [$];
    logic [SYM_W-1:0] alpha [$];

    int  total_beats = 0;
    int  taken_cnt   = 0;
    int  checked_cnt = 0;
    int  found_cnt   = 0;
    int  miss_cnt    = 0;
    int  fail_cnt    = 0;
    int  idle_cycles = 0;
    bit  in_taken    = 1'b0;
    int  gap_left    = 0;
    int  burst_left  = 0;
    int  tx_pick;
    int  stall_left  = 0;
    int  free_left   = 0;
    int  rx_hold_left = 0;
    bit  hold_done   = 1'b0;
    int  rx_pick;
    int  rand_goal;
    int  seq_pick;
    int  n_texts;
    int  n_pat;
    t_out_beat want;

    function automatic void clear_search();
        match_len = 0;
        txt_pos   = 0;
        hit_done  = 1'b0;
    endfunction

    function automatic void close_pattern();
        int unsigned i = 1;
        int unsigned k = 0;
        if (!pat_bad && pat_len != 0) begin
            lps_mem[0] = 0;
            while (i < pat_len) begin
                if (pat_mem[i] == pat_mem[k]) begin
                    k++;
                    lps_mem[i] = k;
                    i++;
                end else if (k != 0) begin
                    k = lps_mem[k-1];
                end else begin
                    lps_mem[i] = 0;
                    i++;
                end
            end
        end
        pat_loading = 1'b0;
        clear_search();
    endfunction

    function automatic void search_predict(t_in_beat b);
        t_out_beat       r;
        longint unsigned start;
        if (b.operation == OP_PATTERN) begin
            if (!pat_loading) begin
                pat_len     = 0;
                pat_bad     = 1'b0;
                pat_loading = 1'b1;
                clear_search();
            end
            if (pat_len < MAX_PATTERN) begin
                pat_mem[pat_len] = b.symbol;
                pat_len++;
            end else begin
                pat_bad = 1'b1;
            end
            if (b.last) close_pattern();
        end else begin
            if (pat_loading) close_pattern();
            if (!hit_done && !pat_bad && pat_len != 0) begin
                while (match_len > 0 && pat_mem[match_len] != b.symbol)
                    match_len = lps_mem[match_len-1];
                if (pat_mem[match_len] == b.symbol) match_len++;
                if (match_len == pat_len) begin
                    start = txt_pos + 1 - pat_len;
                    if (start < MAX_TEXT) begin
                        r.found    = 1'b1;
                        r.position = start[POS_W-1:0];
                        verdict_q.push_back(r);
                        hit_done = 1'b1;
                    end
                    match_len = lps_mem[match_len-1];
                end
            end
            if (txt_pos < TPOS_SAT) txt_pos++;
            if (b.last) begin
                if (!hit_done) begin
                    r = '0;
                    verdict_q.push_back(r);
                end
                clear_search();
            end
        end
    endfunction

    task automatic push_beat(input bit op, input logic [SYM_W-1:0] sym, input bit fin);
        t_in_beat b;
        b.operation = op;
        b.symbol    = sym;
        b.last      = fin;
        beat_q.push_back(b);
        total_beats++;
    endtask

    task automatic push_bytes(input bit op, input bit close);
        foreach (seq_bytes[j])
            push_beat(op, seq_bytes[j], close && j == seq_bytes.size() - 1);
    endtask

    function automatic logic [SYM_W-1:0] pick_sym();
        if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, 255));
        return alpha[$urandom_range(0, alpha.size() - 1)];
    endfunction

    always #5 i_clk = ~i_clk;

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left != 0 && rx_hold_left == 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (beat_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= beat_q.pop_front();
                tx_pick = $urandom_range(0, 99);
                if (burst_left != 0) begin
                    burst_left <= burst_left - 1;
                    gap_left   <= 0;
                end else if (tx_pick < 2) begin
                    burst_left <= $urandom_range(50, 300);
                    gap_left   <= 0;
                end else if (tx_pick < 60) begin
                    gap_left <= 0;
                end else if (tx_pick < 90) begin
                    gap_left <= $urandom_range(1, 3);
                end else if (tx_pick < 98) begin
                    gap_left <= $urandom_range(4, 15);
                end else begin
                    gap_left <= $urandom_range(20, 60);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!hold_done && checked_cnt >= HOLD_AT) begin
            hold_done    <= 1'b1;
            rx_hold_left <= HOLD_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_stall  <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (free_left != 0) begin
            free_left   <= free_left - 1;
            i_out_stall <= 1'b0;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 40)      stall_left <= $urandom_range(1, 3);
            else if (rx_pick < 47) stall_left <= $urandom_range(8, 40);
            else if (rx_pick < 95) free_left  <= $urandom_range(1, 15);
            else                   free_left  <= $urandom_range(100, 300);
            i_out_stall <= 1'b0;
        end
    end

    // beat monitor and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                search_predict(i_in_data);
                taken_cnt++;
            end
            if (o_out_valid && !i_out_stall) begin
                checked_cnt++;
                if (verdict_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN_FAILS)
                        $display("%0t: unexpected beat, expected none, actual %0b/%0d",
                                 $time, o_out_data.found, o_out_data.position);
                end else begin
                    want = verdict_q.pop_front();
                    if (want.found) found_cnt++;
                    else miss_cnt++;
                    if (o_out_data.found !== want.found) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_SHOWN_FAILS)
                            $display("%0t: found mismatch, expected %0b actual %0b",
                                     $time, want.found, o_out_data.found);
                    end
                    if (o_out_data.position !== want.position) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_SHOWN_FAILS)
                            $display("%0t: position mismatch, expected %0d actual %0d",
                                     $time, want.position, o_out_data.position);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("kmp_substring_search_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;

        // no pattern loaded yet
        push_beat(OP_TEXT, 8'h00, 1'b1);
        push_beat(OP_PATTERN, 8'hFF, 1'b1);
        push_beat(OP_TEXT, 8'h00, 1'b0);
        push_beat(OP_TEXT, 8'hFF, 1'b1);
        // overlapping matches, only the first reported
        push_beat(OP_PATTERN, 8'h00, 1'b0);
        push_beat(OP_PATTERN, 8'h00, 1'b1);
        repeat (3) push_beat(OP_TEXT, 8'h00, 1'b0);
        push_beat(OP_TEXT, 8'h00, 1'b1);
        // text beat closes an open pattern
        push_beat(OP_PATTERN, 8'hAB, 1'b0);
        push_beat(OP_PATTERN, 8'hCD, 1'b0);
        push_beat(OP_TEXT, 8'hAB, 1'b0);
        push_beat(OP_TEXT, 8'hCD, 1'b1);
        // fallback through the failure table
        push_beat(OP_PATTERN, 8'h41, 1'b0);
        push_beat(OP_PATTERN, 8'h41, 1'b0);
        push_beat(OP_PATTERN, 8'h42, 1'b1);
        repeat (3) push_beat(OP_TEXT, 8'h41, 1'b0);
        push_beat(OP_TEXT, 8'h42, 1'b1);
        push_beat(OP_TEXT, 8'h42, 1'b1);
        // new pattern cuts a text short
        push_beat(OP_TEXT, 8'h41, 1'b0);
        push_beat(OP_PATTERN, 8'h7E, 1'b1);
        push_beat(OP_TEXT, 8'h7E, 1'b1);

        // one byte more than the store holds
        pat_bytes = {};
        repeat (MAX_PATTERN) pat_bytes.push_back($urandom_range(0, 1) ? 8'h5A : 8'hA5);
        seq_bytes = pat_bytes;
        push_bytes(OP_PATTERN, 1'b0);
        push_beat(OP_PATTERN, 8'h5A, 1'b1);
        seq_bytes = pat_bytes[0:5];
        push_bytes(OP_TEXT, 1'b1);

        rand_goal = total_beats + RANDOM_BEATS;
        while (total_beats < rand_goal) begin
            seq_pick = $urandom_range(0, 99);
            alpha = {};
            repeat ($urandom_range(1, 4)) alpha.push_back(SYM_W'($urandom_range(0, 255)));
            n_pat = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 24);
            pat_bytes = {};
            repeat (n_pat) pat_bytes.push_back(pick_sym());
            seq_bytes = pat_bytes;
            push_bytes(OP_PATTERN, seq_pick >= 10);
            n_texts = $urandom_range(1, 4);
            for (int t = 0; t < n_texts; t++) begin
                seq_bytes = {};
                repeat ($urandom_range(0, 12)) seq_bytes.push_back(pick_sym());
                if ($urandom_range(0, 1))
                    foreach (pat_bytes[j]) seq_bytes.push_back(pat_bytes[j]);
                repeat ($urandom_range(0, 12)) seq_bytes.push_back(pick_sym());
                if (seq_bytes.size() == 0) seq_bytes.push_back(pick_sym());
                push_bytes(OP_TEXT, !(seq_pick >= 10 && seq_pick < 20 && t == n_texts - 1));
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_cnt != total_beats) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d beats taken: directed cases, an overlong pattern, random texts",
                 taken_cnt);
        $display("%0d results checked, %0d matches, %0d not found, one long output hold",
                 checked_cnt, found_cnt, miss_cnt);
        if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("kmp_substring_search_core test passed");
        end else begin
            $display("kmp_substring_search_core test failed");
        end
        $finish;
    end

endmodule
